### hw/rtl/fpa_pkg.sv
// Shared opcode codes and pipeline side-band type for the fixed-point ALU.
package fpa_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_GT       = 4'd4,
        FN_LT       = 4'd5,
        FN_GE       = 4'd6,
        FN_LE       = 4'd7,
        FN_EQ       = 4'd8,
        FN_NE       = 4'd9,
        FN_MIN      = 4'd10,
        FN_MAX      = 4'd11,
        FN_INC      = 4'd12,
        FN_DEC      = 4'd13,
        FN_FROM_INT = 4'd14,
        FN_TO_INT   = 4'd15
    } func_t;

    // Fields that ride along the divider row next to the partial quotient.
    typedef struct packed {
        func_t              func;
        logic [WORD_W-1:0]  res;   // finished result of every non-divide op
        logic               cmp;
        logic               dz;
        logic               neg;   // quotient sign
    } side_t;

endpackage

### hw/rtl/fixed_point_alu.sv
// Pipeline: each accepted input item passes one entry stage, 32 + FRAC_BITS
//   divider cells and one output register on its way to its result item.
// Throughput: one item per cycle while the output is not stalled; every item walks
//   the full divider row, one quotient bit per cell, so all operations share the same latency.
// Stall: the whole row holds while the output item waits and m_tready is low.
// Reset: aresetn low clears all valid bits at the next clock edge; data registers are not reset.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [3:0]   s_tuser,   // [3:0] func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [31:0] result_value
    output logic [1:0]   m_tuser    // [0] compare_true, [1] divide_by_zero
);

    // One cell per quotient bit: |a| << FRAC_BITS needs 32 + FRAC_BITS bits.
    localparam int unsigned QW = 32 + FRAC_BITS;

    logic           en;
    logic           vld_w  [0:QW];
    side_t          side_w [0:QW];
    logic [31:0]    rem_w  [0:QW];
    logic [QW-1:0]  nq_w   [0:QW];
    logic [31:0]    d_w    [0:QW];

    // Advance the whole pipe whenever the output register is free or being drained.
    assign en       = ~m_tvalid | m_tready;
    assign s_tready = en;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .func      (s_tuser),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .vld_reg   (vld_w[0]),
        .side_reg  (side_w[0]),
        .nq_reg    (nq_w[0]),
        .d_reg     (d_w[0])
    );

    // Partial remainder starts empty at the head of the row.
    assign rem_w[0] = '0;

    for (genvar i = 0; i < QW; i++) begin : g_cell
        fpa_div_cell #(
            .QW (QW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .vld_in   (vld_w[i]),
            .side_in  (side_w[i]),
            .rem_in   (rem_w[i]),
            .nq_in    (nq_w[i]),
            .d_in     (d_w[i]),
            .vld_reg  (vld_w[i+1]),
            .side_reg (side_w[i+1]),
            .rem_reg  (rem_w[i+1]),
            .nq_reg   (nq_w[i+1]),
            .d_reg    (d_w[i+1])
        );
    end

    // After the last cell the numerator register holds the quotient magnitude.
    fpa_back #(
        .QW (QW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (vld_w[QW]),
        .side_in (side_w[QW]),
        .quo_in  (nq_w[QW]),
        .vld_reg (m_tvalid),
        .res_reg (m_tdata),
        .cmp_reg (m_tuser[0]),
        .dz_reg  (m_tuser[1])
    );

endmodule

### hw/rtl/fpa_front.sv
// Entry stage: decode, all non-divide ops including multiply, and divider operand setup.
module fpa_front
    import fpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 8,
    parameter int unsigned QW        = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [3:0]          func,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    output logic                vld_reg,
    output side_t               side_reg,
    output logic [QW-1:0]       nq_reg,
    output logic [31:0]         d_reg
);

    side_t                side_next;
    logic signed [63:0]   prod;
    logic signed [63:0]   prod_sh;
    logic [31:0]          amag;
    logic [31:0]          bmag;

    always_comb begin
        prod    = 64'(operand_a) * 64'(operand_b);
        prod_sh = prod >>> FRAC_BITS;
        amag    = operand_a[31] ? 32'(-operand_a) : operand_a;
        bmag    = operand_b[31] ? 32'(-operand_b) : operand_b;

        side_next.func = func_t'(func);
        side_next.res  = '0;
        side_next.cmp  = 1'b0;
        side_next.dz   = 1'b0;
        side_next.neg  = operand_a[31] ^ operand_b[31];
        case (func_t'(func))
            FN_ADD:      side_next.res = operand_a + operand_b;
            FN_SUB:      side_next.res = operand_a - operand_b;
            FN_MUL:      side_next.res = prod_sh[31:0];
            FN_DIV:      side_next.dz  = (operand_b == 32'sd0);
            FN_GT:       side_next.cmp = (operand_a >  operand_b);
            FN_LT:       side_next.cmp = (operand_a <  operand_b);
            FN_GE:       side_next.cmp = (operand_a >= operand_b);
            FN_LE:       side_next.cmp = (operand_a <= operand_b);
            FN_EQ:       side_next.cmp = (operand_a == operand_b);
            FN_NE:       side_next.cmp = (operand_a != operand_b);
            FN_MIN:      side_next.res = (operand_b < operand_a) ? operand_b : operand_a;
            FN_MAX:      side_next.res = (operand_b > operand_a) ? operand_b : operand_a;
            FN_INC:      side_next.res = operand_a + 32'sd1;
            FN_DEC:      side_next.res = operand_a - 32'sd1;
            FN_FROM_INT: side_next.res = operand_a << FRAC_BITS;
            FN_TO_INT:   side_next.res = operand_a >>> FRAC_BITS;
            default:     side_next.res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            nq_reg   <= QW'(amag) << FRAC_BITS;
            d_reg    <= bmag;
        end
    end

endmodule

### hw/rtl/fpa_div_cell.sv
// One restoring-divide cell: retire one quotient bit and pass the item on.
module fpa_div_cell
    import fpa_pkg::*;
#(
    parameter int unsigned QW = 40
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_in,
    input  side_t          side_in,
    input  logic [31:0]    rem_in,
    input  logic [QW-1:0]  nq_in,
    input  logic [31:0]    d_in,
    output logic           vld_reg,
    output side_t          side_reg,
    output logic [31:0]    rem_reg,
    output logic [QW-1:0]  nq_reg,
    output logic [31:0]    d_reg
);

    logic [33:0]    diff;
    logic           ge;
    logic [31:0]    rem_next;
    logic [QW-1:0]  nq_next;

    // Shift the next numerator bit into the remainder, trial-subtract the divisor.
    always_comb begin
        diff     = {1'b0, rem_in, nq_in[QW-1]} - {2'b00, d_in};
        ge       = ~diff[33];
        rem_next = ge ? diff[31:0] : {rem_in[30:0], nq_in[QW-1]};
        nq_next  = {nq_in[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_in;
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            d_reg    <= d_in;
        end
    end

endmodule

### hw/rtl/fpa_back.sv
// Output stage: apply quotient sign, pick the result, hold the output item.
module fpa_back
    import fpa_pkg::*;
#(
    parameter int unsigned QW = 40
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_in,
    input  side_t          side_in,
    input  logic [QW-1:0]  quo_in,
    output logic           vld_reg,
    output logic [31:0]    res_reg,
    output logic           cmp_reg,
    output logic           dz_reg
);

    logic [QW-1:0]  quo_signed;
    logic [31:0]    res_next;

    always_comb begin
        quo_signed = side_in.neg ? (~quo_in + QW'(1)) : quo_in;
        if (side_in.func == FN_DIV) begin
            res_next = side_in.dz ? 32'd0 : quo_signed[31:0];
        end else begin
            res_next = side_in.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
            cmp_reg <= side_in.cmp;
            dz_reg  <= side_in.dz;
        end
    end

endmodule

### hw/rtl/fpa_checker.sv
// Port-level checks for the fixed-point ALU, bound to its top level.
module fpa_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic [1:0]   m_tuser
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("compare and divide-by-zero flags both set");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
        else $error("divide by zero gave nonzero result");

    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("true compare gave nonzero result");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
